### design/vmtpf_pkg.sv
// Shared types, constants and helpers for the voice mix two-pole filter.
// Used by vmtpf_ctrl, vmtpf_datapath and the top level; depends on nothing.
package vmtpf_pkg;

   // Field widths that the interface fixes.
   localparam int MIX_WIDTH       = 10;
   localparam int SAMPLE_WIDTH    = 8;
   localparam int COEF_WIDTH      = 8;
   localparam int MODE_WIDTH      = 2;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 8;

   // Default accumulator width and the fixed-point scale.
   localparam int ACC_WIDTH_DEF = 16;
   localparam int SCALE         = 7;
   localparam int CLIP_HI       = 127;
   localparam int CLIP_LO       = -127;

   // Filter mode codes.
   localparam logic [MODE_WIDTH-1:0] MODE_OFF     = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_LOWPASS = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_SIMPLE  = 2'd2;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FILTER_MODE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEF_C      = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEF_RC     = 2'd2;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL2,
      ST_UPD1,
      ST_MUL3,
      ST_DONE
   } state_type;

   // Datapath step codes.
   typedef enum logic [2:0] {
      STEP_NONE,
      STEP_MUL1,
      STEP_MUL2,
      STEP_UPD1,
      STEP_MUL3,
      STEP_DONE
   } step_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      step_type step;
      logic     load_x;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic filter_on;
   } status_type;

   // Halve the mixed sample with an arithmetic shift and clip it to +/-127.
   function automatic logic signed [SAMPLE_WIDTH-1:0] clip_half(
      input logic signed [MIX_WIDTH-1:0] mix
   );
      logic signed [MIX_WIDTH-2:0] half;
      half = mix[MIX_WIDTH-1:1];
      if (half > (MIX_WIDTH-1)'(CLIP_HI)) begin
         return SAMPLE_WIDTH'(CLIP_HI);
      end else if (half < (MIX_WIDTH-1)'(CLIP_LO)) begin
         return SAMPLE_WIDTH'(CLIP_LO);
      end
      return half[SAMPLE_WIDTH-1:0];
   endfunction

endpackage

### design/voice_mix_two_pole_filter_unit.sv
// Top level of the voice mix two-pole filter: joins the sequencer and the
// datapath. Depends on vmtpf_pkg, vmtpf_ctrl and vmtpf_datapath.
//
// Usage:
// The req channel takes one summed voice sample per beat (req_mix_sum). The
// rsp channel returns one beat per input: the clipped second stage value and
// its PWM code. The csr channel writes filter_mode (index 0), coef_c (1) and
// coef_rc (2); it is always ready, and any filter_mode write clears both
// filter stages. Write it only while the block is idle.
// Sequence: in the lowpass and simple modes an item runs through the first
// dual-product step in the accepting cycle, then the second, a stage one
// update, one more product step and the commit; in the off mode it goes
// straight to the commit. The result is valid once the commit is done, and a
// new item is taken only after the last one has been committed. The shared
// accumulator and its two multipliers make the product steps run in turn.
// A finished result sits in the output register; the next item is accepted
// and worked on while it waits. If the receiver still stalls when the next
// result is ready, the commit step holds until the register drains.
// Reset (synchronous, active high) clears the mode, coefficients, both stages
// and the result valid.
module voice_mix_two_pole_filter_unit #(
   parameter int ACC_WIDTH = vmtpf_pkg::ACC_WIDTH_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_ready,
   input  logic signed [vmtpf_pkg::MIX_WIDTH-1:0]     req_mix_sum,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output logic signed [vmtpf_pkg::SAMPLE_WIDTH-1:0]  rsp_filtered_sample,
   output logic [vmtpf_pkg::SAMPLE_WIDTH-1:0]         rsp_pwm_code,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [vmtpf_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [vmtpf_pkg::CSR_DATA_WIDTH-1:0]       csr_data
);
   import vmtpf_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Registers can be written in any cycle.
   assign csr_ready = 1'b1;

   // Sequencer.
   vmtpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath.
   vmtpf_datapath #(
      .ACC_WIDTH (ACC_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_mix_sum     (req_mix_sum),
      .cmd             (cmd),
      .status          (status),
      .filtered_sample (rsp_filtered_sample),
      .pwm_code        (rsp_pwm_code)
   );

endmodule

### design/vmtpf_ctrl.sv
// Sequencer of the voice mix two-pole filter: walks one item through the
// multiply, update and commit steps. Depends on vmtpf_pkg.
module vmtpf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  vmtpf_pkg::status_type  status,
   output vmtpf_pkg::cmd_type     cmd
);
   import vmtpf_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The output register can take a result when empty or when drained now.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = status.filter_on ? ST_MUL2 : ST_DONE;
            end
         end
         ST_MUL2: state_in = ST_UPD1;
         ST_UPD1: state_in = ST_MUL3;
         ST_MUL3: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands and handshake outputs.
   always_comb begin
      req_ready   = 1'b0;
      cmd.step    = STEP_NONE;
      cmd.load_x  = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.load_x = req_valid;
            if (req_valid && status.filter_on) begin
               cmd.step = STEP_MUL1;
            end
         end
         ST_MUL2: cmd.step = STEP_MUL2;
         ST_UPD1: cmd.step = STEP_UPD1;
         ST_MUL3: cmd.step = STEP_MUL3;
         ST_DONE: begin
            if (out_free) begin
               cmd.step     = STEP_DONE;
               rsp_valid_in = 1'b1;
            end
         end
         default: cmd.step = STEP_NONE;
      endcase
   end

   // State and result-valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // An accepted item in a filtering mode moves on to the second product.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && status.filter_on) |=> (state_ff == ST_MUL2))
      else $error("filter item did not advance to the second product step");

   // A result only appears out of the commit step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result valid raised outside the commit step");

   // A blocked commit waits without touching the datapath.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && !rsp_ready) |->
      (cmd.step == STEP_NONE) ##1 (state_ff == ST_DONE))
      else $error("commit did not wait for the output register");

endmodule

### design/vmtpf_datapath.sv
// Datapath of the voice mix two-pole filter: configuration registers, the
// two filter stages and a dual-product accumulator. Depends on vmtpf_pkg.
module vmtpf_datapath #(
   parameter int ACC_WIDTH = vmtpf_pkg::ACC_WIDTH_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          csr_write,
   input  logic [vmtpf_pkg::CSR_INDEX_WIDTH-1:0]         csr_index,
   input  logic [vmtpf_pkg::CSR_DATA_WIDTH-1:0]          csr_data,
   input  logic signed [vmtpf_pkg::MIX_WIDTH-1:0]        req_mix_sum,
   input  vmtpf_pkg::cmd_type                            cmd,
   output vmtpf_pkg::status_type                         status,
   output logic signed [vmtpf_pkg::SAMPLE_WIDTH-1:0]     filtered_sample,
   output logic [vmtpf_pkg::SAMPLE_WIDTH-1:0]            pwm_code
);
   import vmtpf_pkg::*;

   // Configuration and filter state.
   logic [MODE_WIDTH-1:0]          mode_ff;
   logic signed [COEF_WIDTH-1:0]   coef_c_ff;
   logic signed [COEF_WIDTH-1:0]   coef_rc_ff;
   logic signed [ACC_WIDTH-1:0]    s1_ff, s1_in;
   logic signed [SAMPLE_WIDTH-1:0] s2_ff;

   // Working registers and output payload.
   logic signed [SAMPLE_WIDTH-1:0] x_ff;
   logic signed [ACC_WIDTH-1:0]    acc_ff, acc_in;
   logic signed [SAMPLE_WIDTH-1:0] out_sample_ff;
   logic [SAMPLE_WIDTH-1:0]        out_pwm_ff;

   logic                           mode_simple;
   logic signed [SAMPLE_WIDTH-1:0] x_now;
   logic signed [ACC_WIDTH-1:0]    opa, opb, prod_a, prod_b, term_a, term_b, base;
   logic signed [COEF_WIDTH-1:0]   cfa, cfb;
   logic                           nega, negb, keep_acc;
   logic signed [ACC_WIDTH-1:0]    shifted, s2_wide, s2_sum;
   logic signed [SAMPLE_WIDTH-1:0] s2_clip;

   assign mode_simple      = (mode_ff == MODE_SIMPLE);
   assign status.filter_on = (mode_ff == MODE_LOWPASS) || (mode_ff == MODE_SIMPLE);
   assign x_now            = clip_half(req_mix_sum);

   // Operand selection for each multiply step; lowpass and simple forms differ.
   always_comb begin
      opa      = '0;
      opb      = '0;
      cfa      = '0;
      cfb      = '0;
      nega     = 1'b0;
      negb     = 1'b0;
      keep_acc = 1'b0;
      case (cmd.step)
         STEP_MUL1: begin
            // Lowpass: x*C - s1*C. Simple: x*C + s1*RC.
            opa  = ACC_WIDTH'(x_now);
            cfa  = coef_c_ff;
            opb  = s1_ff;
            cfb  = mode_simple ? coef_rc_ff : coef_c_ff;
            negb = !mode_simple;
         end
         STEP_MUL2: begin
            // Lowpass: + s1*RC - s2*RC. Simple: - s2*C.
            keep_acc = 1'b1;
            opa      = ACC_WIDTH'(s2_ff);
            cfa      = mode_simple ? coef_c_ff : coef_rc_ff;
            nega     = 1'b1;
            opb      = mode_simple ? '0 : s1_ff;
            cfb      = coef_rc_ff;
         end
         STEP_MUL3: begin
            // Lowpass: s1*C - s2*C. Simple: s2*RC + s1*C.
            opa  = ACC_WIDTH'(s2_ff);
            cfa  = mode_simple ? coef_rc_ff : coef_c_ff;
            nega = !mode_simple;
            opb  = s1_ff;
            cfb  = coef_c_ff;
         end
         default: keep_acc = 1'b0;
      endcase
   end

   // Two products side by side; all sums wrap at the accumulator width.
   assign prod_a = opa * ACC_WIDTH'(cfa);
   assign prod_b = opb * ACC_WIDTH'(cfb);
   assign term_a = nega ? -prod_a : prod_a;
   assign term_b = negb ? -prod_b : prod_b;
   assign base   = keep_acc ? acc_ff : '0;
   assign acc_in = base + term_a + term_b;

   // Stage updates from the scaled accumulator.
   assign shifted = acc_ff >>> SCALE;
   assign s1_in   = mode_simple ? (s1_ff - shifted) : (s1_ff + shifted);
   assign s2_wide = ACC_WIDTH'(s2_ff);

   always_comb begin
      if (!status.filter_on) begin
         s2_sum = ACC_WIDTH'(x_ff);
      end else if (mode_simple) begin
         s2_sum = s2_wide - shifted;
      end else begin
         s2_sum = s2_wide + shifted;
      end
      if (s2_sum > ACC_WIDTH'(CLIP_HI)) begin
         s2_clip = SAMPLE_WIDTH'(CLIP_HI);
      end else if (s2_sum < ACC_WIDTH'(CLIP_LO)) begin
         s2_clip = SAMPLE_WIDTH'(CLIP_LO);
      end else begin
         s2_clip = s2_sum[SAMPLE_WIDTH-1:0];
      end
   end

   // Configuration and stage registers; a mode write clears both stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_OFF;
         coef_c_ff  <= '0;
         coef_rc_ff <= '0;
         s1_ff      <= '0;
         s2_ff      <= '0;
      end else begin
         if (cmd.step == STEP_UPD1) begin
            s1_ff <= s1_in;
         end
         if (cmd.step == STEP_DONE) begin
            s2_ff <= s2_clip;
         end
         if (csr_write) begin
            case (csr_index)
               REG_FILTER_MODE: begin
                  mode_ff <= csr_data[MODE_WIDTH-1:0];
                  s1_ff   <= '0;
                  s2_ff   <= '0;
               end
               REG_COEF_C:  coef_c_ff  <= csr_data[COEF_WIDTH-1:0];
               REG_COEF_RC: coef_rc_ff <= csr_data[COEF_WIDTH-1:0];
               default:     coef_c_ff  <= coef_c_ff;
            endcase
         end
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load_x) begin
         x_ff <= x_now;
      end
      if (cmd.step == STEP_MUL1 || cmd.step == STEP_MUL2 || cmd.step == STEP_MUL3) begin
         acc_ff <= acc_in;
      end
      if (cmd.step == STEP_DONE) begin
         out_sample_ff <= s2_clip;
         out_pwm_ff    <= SAMPLE_WIDTH'(s2_clip) + SAMPLE_WIDTH'(CLIP_HI);
      end
   end

   assign filtered_sample = out_sample_ff;
   assign pwm_code        = out_pwm_ff;

   // Stage two never reaches the most negative code.
   assert property (@(posedge clock) disable iff (reset)
      s2_ff != SAMPLE_WIDTH'(CLIP_LO - 1))
      else $error("stage two left the clip range");

   // The PWM code tracks the committed sample with its offset.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.step == STEP_DONE) |=>
      (out_pwm_ff == SAMPLE_WIDTH'(out_sample_ff) + SAMPLE_WIDTH'(CLIP_HI)))
      else $error("PWM code does not match the committed sample");

endmodule
